// ----- sv/kbs_pkg.sv -----
package kbs_pkg;

  localparam int KEY_BYTES = 8;
  localparam int PW_WORDS  = 4;
  localparam int WORD_BITS = 64;

  // packet offsets
  localparam logic [8:0] FIRST_AT  = 9'h039;
  localparam logic [8:0] SECOND_AT = 9'h041;
  localparam logic [8:0] KEY_BASE  = 9'h0B8;
  localparam logic [8:0] CNT_MAX   = 9'd511;
  localparam logic [8:0] KEY_SPAN  = 9'd8;
  localparam logic [8:0] FIELD_SPAN = 9'd4;
  localparam logic [3:0] KEY_FULL  = 4'd8;

  // payload burst
  localparam logic [5:0] LAST_WORD_IDX = 6'd63;

  // configuration register indexes
  localparam logic [1:0] REG_PW_WORD_0 = 2'd0;
  localparam logic [1:0] REG_PW_WORD_1 = 2'd1;
  localparam logic [1:0] REG_PW_WORD_2 = 2'd2;
  localparam logic [1:0] REG_PW_WORD_3 = 2'd3;

  typedef logic [7:0] byte_t;
  typedef byte_t [KEY_BYTES-1:0] key_vec_t;
  typedef logic [PW_WORDS-1:0][WORD_BITS-1:0] pw_t;

  typedef struct packed {
    key_vec_t keys;
    logic     missing;
  } snap_t;

endpackage

// ----- sv/kbs_in_if.sv -----
interface kbs_in_if;
  logic             valid;
  logic             ready;
  kbs_pkg::byte_t   packet_byte;
  logic             last_byte;

  modport source (output valid, output packet_byte, output last_byte, input ready);
  modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

// ----- sv/kbs_out_if.sv -----
interface kbs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_word;
  logic        last_word;
  logic        key_missing;

  modport source (output valid, output out_word, output last_word, output key_missing,
                  input ready);
  modport sink   (input valid, input out_word, input last_word, input key_missing,
                  output ready);
endinterface

// ----- sv/kbs_capture.sv -----
module kbs_capture (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  kbs_pkg::byte_t  in_byte,
  input  logic            in_last,
  input  logic            take,
  output logic            pend,
  output kbs_pkg::snap_t  snap
);

  logic [8:0]        cnt_r, cnt_nxt;
  logic [31:0]       f_r, f_nxt;
  logic [31:0]       s_r, s_nxt;
  kbs_pkg::key_vec_t keys_r, keys_nxt;
  logic [3:0]        kc_r, kc_nxt;
  logic              pend_r, pend_nxt;

  logic [8:0]  fd, sd, kd, koff;
  logic [7:0]  ksum;
  logic [31:0] f_cap, s_cap;

  assign fd = cnt_r - kbs_pkg::FIRST_AT;
  assign sd = cnt_r - kbs_pkg::SECOND_AT;

  // word fields with the current byte dropped in place
  always_comb begin
    f_cap = f_r;
    s_cap = s_r;
    if (cnt_r >= kbs_pkg::FIRST_AT && fd < kbs_pkg::FIELD_SPAN)
      f_cap[{~fd[1:0], 3'b000} +: 8] = in_byte;
    if (cnt_r >= kbs_pkg::SECOND_AT && sd < kbs_pkg::FIELD_SPAN)
      s_cap[{~sd[1:0], 3'b000} +: 8] = in_byte;
  end

  assign ksum = f_cap[7:0] + s_cap[7:0];
  assign koff = {1'b0, ksum} + kbs_pkg::KEY_BASE;
  assign kd = cnt_r - koff;

  always_comb begin
    cnt_nxt  = cnt_r;
    f_nxt    = f_r;
    s_nxt    = s_r;
    keys_nxt = keys_r;
    kc_nxt   = kc_r;
    pend_nxt = pend_r;
    if (take) begin
      // hand the finished packet over, start clean
      cnt_nxt  = '0;
      f_nxt    = '0;
      s_nxt    = '0;
      keys_nxt = '0;
      kc_nxt   = '0;
      pend_nxt = 1'b0;
    end else if (in_fire) begin
      f_nxt = f_cap;
      s_nxt = s_cap;
      if (cnt_r >= koff && kd < kbs_pkg::KEY_SPAN) begin
        keys_nxt[kd[2:0]] = in_byte;
        if (kc_r < kbs_pkg::KEY_FULL)
          kc_nxt = kc_r + 4'd1;
      end
      if (cnt_r != kbs_pkg::CNT_MAX)
        cnt_nxt = cnt_r + 9'd1;
      if (in_last)
        pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      f_r    <= '0;
      s_r    <= '0;
      keys_r <= '0;
      kc_r   <= '0;
      pend_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      f_r    <= f_nxt;
      s_r    <= s_nxt;
      keys_r <= keys_nxt;
      kc_r   <= kc_nxt;
      pend_r <= pend_nxt;
    end
  end

  assign pend         = pend_r;
  assign snap.keys    = keys_r;
  assign snap.missing = kc_r < kbs_pkg::KEY_FULL;

endmodule

// ----- sv/kbs_emit.sv -----
module kbs_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pend,
  input  kbs_pkg::snap_t  snap,
  input  kbs_pkg::pw_t    pw,
  output logic            take,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [63:0]     out_word,
  output logic            last_word,
  output logic            key_missing
);

  logic              busy_r, busy_nxt;
  logic [5:0]        idx_r, idx_nxt;
  kbs_pkg::key_vec_t keys_r, keys_nxt;
  logic              miss_r, miss_nxt;
  logic [15:0]       acc_r, acc_nxt;

  logic              ov_r, ov_nxt;
  logic [63:0]       word_r, word_nxt;
  logic              lw_r, lw_nxt;
  logic              km_r, km_nxt;

  logic [255:0]      pw_flat;
  logic [2:0]        pos;
  logic [9:0]        rel  [8];
  logic [7:0]        raw  [8];
  logic [7:0]        jb   [8];
  logic              bitv [8];
  logic [15:0]       hsum;
  logic [63:0]       gen;
  logic              adv;
  logic              at_end;

  assign pw_flat = {pw[0], pw[1], pw[2], pw[3]};
  assign pos     = keys_r[1][2:0];
  assign take    = pend && !busy_r;
  assign adv     = busy_r && (!ov_r || out_ready);
  assign at_end  = idx_r == kbs_pkg::LAST_WORD_IDX;

  // one payload byte per lane; data bit j sits at byte start+j
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      rel[k]  = {1'b0, idx_r, 3'(k)} - {2'b00, keys_r[0]};
      jb[k]   = rel[k][7:0];
      bitv[k] = ~(pw_flat[~jb[k]] ^ keys_r[jb[k][7:5]][jb[k][4:2]]);
      raw[k]  = (rel[k][9:8] == 2'b00) ? 8'({7'b0, bitv[k]} << pos) : 8'h00;
    end
  end

  assign hsum = acc_r + {raw[0], raw[1]} + {raw[2], raw[3]}
                      + {raw[4], raw[5]} + {raw[6], raw[7]};
  assign gen  = {raw[0], raw[1], raw[2], raw[3], raw[4], raw[5],
                 at_end ? hsum : {raw[6], raw[7]}};

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    keys_nxt = keys_r;
    miss_nxt = miss_r;
    acc_nxt  = acc_r;
    ov_nxt   = ov_r;
    word_nxt = word_r;
    lw_nxt   = lw_r;
    km_nxt   = km_r;
    if (take) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      keys_nxt = snap.keys;
      miss_nxt = snap.missing;
      acc_nxt  = '0;
    end
    if (adv) begin
      ov_nxt   = 1'b1;
      word_nxt = gen;
      lw_nxt   = at_end;
      km_nxt   = miss_r;
      acc_nxt  = hsum;
      idx_nxt  = idx_r + 6'd1;
      if (at_end)
        busy_nxt = 1'b0;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      idx_r  <= '0;
      acc_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
      idx_r  <= idx_nxt;
      acc_r  <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    keys_r <= keys_nxt;
    miss_r <= miss_nxt;
    word_r <= word_nxt;
    lw_r   <= lw_nxt;
    km_r   <= km_nxt;
  end

  assign out_valid   = ov_r;
  assign out_word    = word_r;
  assign last_word   = lw_r;
  assign key_missing = km_r;

endmodule

// ----- sv/keyed_response_bit_scrambler.sv -----
// Keyed response bit scrambler. Request packet bytes enter on in_bus, one beat
// per cycle while in_bus.ready is high. The capture stage picks up the two
// big-endian words at offsets 0x39 and 0x41 and the eight key bytes that start
// at 0xB8 plus the low byte of their sum. A beat with last_byte set closes the
// packet; the emitter then sends a 512-byte payload on out_bus as 64 beats of
// 64 bits, one beat per cycle while out_bus.ready is high. With the emitter
// idle, the last byte sets pend, the handover sets busy_r, then valid rises.
// Each word is built in one pass from the key snapshot and the password
// registers; the running sum of the payload's 16-bit words is carried word to
// word and lands in the low 16 bits of the 64th beat (last_word). key_missing
// marks every beat of a packet that ended before all eight key bytes arrived.
// Bytes of the next packet are taken while a burst is still going out. After
// every last byte in_bus.ready drops: the finished packet waits in the capture
// stage until the emitter is free and takes it, and ready stays low until that
// handover. Write the password registers only while idle.
module keyed_response_bit_scrambler (
  input  logic        clk,
  input  logic        rst_n,
  kbs_in_if.sink      in_bus,
  kbs_out_if.source   out_bus,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  kbs_pkg::pw_t   pw_r, pw_nxt;
  kbs_pkg::snap_t snap;
  logic           pend;
  logic           take;
  logic           in_fire;

  // hold input while a finished packet is still waiting for the emitter
  assign in_bus.ready = !pend;
  assign in_fire      = in_bus.valid && in_bus.ready;

  // password registers
  always_comb begin
    pw_nxt = pw_r;
    if (cfg_we) begin
      case (cfg_index)
        kbs_pkg::REG_PW_WORD_0: pw_nxt[0] = cfg_data;
        kbs_pkg::REG_PW_WORD_1: pw_nxt[1] = cfg_data;
        kbs_pkg::REG_PW_WORD_2: pw_nxt[2] = cfg_data;
        kbs_pkg::REG_PW_WORD_3: pw_nxt[3] = cfg_data;
        default: pw_nxt = pw_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_r <= '0;
    end else begin
      pw_r <= pw_nxt;
    end
  end

  // packet capture: offsets, key window, byte counter
  kbs_capture u_capture (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_bus.packet_byte),
    .in_last (in_bus.last_byte),
    .take    (take),
    .pend    (pend),
    .snap    (snap)
  );

  // payload generation and output register
  kbs_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .pend        (pend),
    .snap        (snap),
    .pw          (pw_r),
    .take        (take),
    .out_valid   (out_bus.valid),
    .out_ready   (out_bus.ready),
    .out_word    (out_bus.out_word),
    .last_word   (out_bus.last_word),
    .key_missing (out_bus.key_missing)
  );

endmodule

// ----- tb/kbs_payload_checker.sv -----
module kbs_payload_checker
  import kbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  byte_t       in_byte,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_word,
  input  logic        out_last,
  input  logic        out_missing,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int unsigned fail_count,
  output int unsigned pending
);

  localparam int PAYLOAD_BYTES = 512;
  localparam int DATA_BITS     = 256;

  typedef struct packed {
    logic [63:0] word;
    logic        last;
    logic        missing;
  } payload_beat_t;

  payload_beat_t expected_beats [$];
  pw_t           password;
  logic [8:0]    byte_idx;
  logic [31:0]   first_word;
  logic [31:0]   second_word;
  key_vec_t      key_bytes;
  logic [3:0]    keys_seen;
  int unsigned   beat_no;

  task automatic report_mismatch(input string what);
    $display("ERROR: beat %0d: %s", beat_no, what);
    fail_count++;
  endtask

  task automatic clear_packet();
    byte_idx    = '0;
    first_word  = '0;
    second_word = '0;
    key_bytes   = '0;
    keys_seen   = '0;
  endtask

  // Capture one packet byte at the current index, then advance the index.
  task automatic take_byte(input byte_t b);
    int unsigned idx;
    int unsigned koff;
    int unsigned sh;
    idx = byte_idx;
    if (idx >= FIRST_AT && idx < FIRST_AT + FIELD_SPAN) begin
      sh = 8 * (3 - (idx - FIRST_AT));
      first_word[sh +: 8] = b;
    end
    if (idx >= SECOND_AT && idx < SECOND_AT + FIELD_SPAN) begin
      sh = 8 * (3 - (idx - SECOND_AT));
      second_word[sh +: 8] = b;
    end
    koff = ((first_word + second_word) & 32'hFF) + KEY_BASE;
    if (idx >= koff && idx < koff + KEY_SPAN) begin
      key_bytes[(idx - koff) % KEY_BYTES] = b;
      if (keys_seen < KEY_FULL) keys_seen++;
    end
    if (byte_idx < CNT_MAX) byte_idx++;
  endtask

  // Build the 512-byte scrambled payload and queue it as 64 beats.
  task automatic queue_payload();
    byte_t         pay [PAYLOAD_BYTES];
    int unsigned   start;
    int unsigned   pos;
    int unsigned   kb;
    logic [31:0]   sum;
    logic          pbit;
    logic          kbit;
    logic [63:0]   w;
    payload_beat_t beat;
    for (int i = 0; i < PAYLOAD_BYTES; i++) pay[i] = '0;
    start = key_bytes[0];
    pos   = key_bytes[1] & 8'h07;
    for (int unsigned j = 0; j < DATA_BITS; j++) begin
      pbit = password[j / WORD_BITS][WORD_BITS - 1 - (j % WORD_BITS)];
      kb   = j >> 2;
      kbit = key_bytes[kb >> 3][kb & 7];
      pay[(start + j) % PAYLOAD_BYTES][pos] = pay[(start + j) % PAYLOAD_BYTES][pos] |
                                              ~(pbit ^ kbit);
    end
    sum = '0;
    for (int j = 0; j < PAYLOAD_BYTES / 2; j++) sum += {pay[2 * j], pay[2 * j + 1]};
    pay[PAYLOAD_BYTES - 2] = sum[15:8];
    pay[PAYLOAD_BYTES - 1] = sum[7:0];
    for (int j = 0; j < PAYLOAD_BYTES / 8; j++) begin
      w = '0;
      for (int k = 0; k < 8; k++) w = {w[55:0], pay[8 * j + k]};
      beat.word    = w;
      beat.last    = (j == LAST_WORD_IDX);
      beat.missing = (keys_seen < KEY_FULL);
      expected_beats.push_back(beat);
    end
    clear_packet();
  endtask

  always @(posedge clk) begin
    payload_beat_t exp_beat;
    if (!rst_n) begin
      password   = '0;
      fail_count = 0;
      beat_no    = 0;
      expected_beats.delete();
      clear_packet();
    end else begin
      if (cfg_we) password[cfg_index] = cfg_data;
      if (in_valid && in_ready) begin
        take_byte(in_byte);
        if (in_last) queue_payload();
      end
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("result beat with nothing pending");
        end else begin
          exp_beat = expected_beats.pop_front();
          if (out_word !== exp_beat.word)
            report_mismatch($sformatf("out_word %h, want %h", out_word, exp_beat.word));
          if (out_last !== exp_beat.last)
            report_mismatch($sformatf("last_word %b, want %b", out_last, exp_beat.last));
          if (out_missing !== exp_beat.missing)
            report_mismatch($sformatf("key_missing %b, want %b", out_missing,
                                      exp_beat.missing));
        end
        beat_no++;
      end
    end
    pending = expected_beats.size();
  end

endmodule

// ----- tb/tb_keyed_response_bit_scrambler.sv -----
module tb_keyed_response_bit_scrambler;
  import kbs_pkg::*;

  localparam int IDLE_PCT      = 31;
  localparam int ITEM_BUDGET   = 470;
  localparam int STEADY_FROM   = 250;
  localparam int STEADY_TO     = 420;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_PKT_BYTES = 256;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        steady;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned stall_cycles = 0;
  int unsigned sent_beats = 0;

  // Packet under construction; only the first pkt_len bytes go out.
  byte_t       pkt [MAX_PKT_BYTES];
  int unsigned pkt_len;

  kbs_in_if  in_bus ();
  kbs_out_if out_bus ();

  keyed_response_bit_scrambler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  kbs_payload_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_bus.valid),
    .in_ready    (in_bus.ready),
    .in_byte     (in_bus.packet_byte),
    .in_last     (in_bus.last_byte),
    .out_valid   (out_bus.valid),
    .out_ready   (out_bus.ready),
    .out_word    (out_bus.out_word),
    .out_last    (out_bus.last_word),
    .out_missing (out_bus.key_missing),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: drop ready about a third of the time, never inside the steady window.
  always @(negedge clk) begin
    out_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog: count cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("keyed_response_bit_scrambler: mismatch");
        $finish;
      end
    end
  end

  // Offer one packet byte, idling first at random; return at the falling edge after
  // the beat is taken, with valid still high so back-to-back beats stay back to back.
  task automatic send_beat(input byte_t b, input logic last);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.packet_byte <= b;
    in_bus.last_byte   <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_packet();
    for (int unsigned i = 0; i < pkt_len; i++) send_beat(pkt[i], i == pkt_len - 1);
    sent_beats += pkt_len;
  endtask

  // Drop valid, hold until every payload beat is out, then let the block settle.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  // Load all four password words; only legal with the block idle.
  task automatic load_passwords(input logic [63:0] w0, w1, w2, w3);
    wait_drained();
    write_reg(REG_PW_WORD_0, w0);
    write_reg(REG_PW_WORD_1, w1);
    write_reg(REG_PW_WORD_2, w2);
    write_reg(REG_PW_WORD_3, w3);
    cfg_we <= 1'b0;
  endtask

  // Password word by mode: random, all zero, all one, or a random pick of those.
  function automatic logic [63:0] pick_word(input int unsigned mode);
    int unsigned m;
    m = (mode > 2) ? $urandom_range(2) : mode;
    case (m)
      1:       return '0;
      2:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic fill_packet(input byte_t value, input bit scatter);
    for (int i = 0; i < MAX_PKT_BYTES; i++) pkt[i] = scatter ? byte_t'($urandom) : value;
  endtask

  // Start of the key window, from the low bytes of the two captured words.
  function automatic int unsigned key_window();
    byte_t lo;
    lo = pkt[FIRST_AT + FIELD_SPAN - 1] + pkt[SECOND_AT + FIELD_SPAN - 1];
    return lo + KEY_BASE;
  endfunction

  // Force the low byte of the word sum by adjusting the second word's last byte.
  task automatic steer_key_window(input byte_t lo);
    pkt[SECOND_AT + FIELD_SPAN - 1] = lo - pkt[FIRST_AT + FIELD_SPAN - 1];
  endtask

  // Random packet of at most room bytes: mostly complete key windows, then
  // cut-short key windows and packets that end around the word fields.
  task automatic random_packet(input int unsigned room);
    int unsigned koff;
    int unsigned pick;
    fill_packet(8'h00, 1'b1);
    // keep the key window near the low end so packets stay short
    steer_key_window(byte_t'($urandom_range(15)));
    koff = key_window();
    if ($urandom_range(4) == 0) pkt[koff] = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
    if ($urandom_range(4) == 0) pkt[koff + 1] = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
    pick = $urandom_range(99);
    if (pick < 60 && koff + KEY_SPAN + 3 <= room) begin
      pkt_len = koff + KEY_SPAN + $urandom_range(3);
    end else if (pick < 75 && koff + KEY_SPAN <= room) begin
      pkt_len = koff + $urandom_range(KEY_SPAN - 1);
    end else begin
      pkt_len = $urandom_range(SECOND_AT + FIELD_SPAN + 2, 1);
      if (pkt_len > room) pkt_len = room;
    end
  endtask

  initial begin
    int unsigned koff;
    int unsigned mode;
    in_bus.valid       = 1'b0;
    in_bus.packet_byte = '0;
    in_bus.last_byte   = 1'b0;
    out_bus.ready      = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_PW_WORD_0;
    cfg_data           = '0;
    steady             = 1'b0;
    rst_n              = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero password first.
    load_passwords('0, '0, '0, '0);
    // packet of one byte: no fields, no keys
    fill_packet(8'hFF, 1'b0);
    pkt_len = 1;
    send_packet();
    // packet that ends inside the first word
    pkt_len = FIRST_AT + 2;
    send_packet();

    load_passwords(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                   64'h8000_0000_0000_0001, 64'h0123_4567_89AB_CDEF);
    // lowest key window with key0 = 255: a data bit lands under the checksum
    fill_packet(8'h00, 1'b1);
    steer_key_window(8'h00);
    koff          = key_window();
    pkt[koff]     = 8'hFF;
    pkt[koff + 1] = 8'h07;
    pkt_len       = koff + KEY_SPAN;
    send_packet();

    // Random part; change passwords now and then between packets.
    while (sent_beats < ITEM_BUDGET) begin
      steady <= (sent_beats >= STEADY_FROM && sent_beats < STEADY_TO);
      if ($urandom_range(99) < 30) begin
        mode = $urandom_range(3);
        load_passwords(pick_word(mode), pick_word(mode), pick_word(mode), pick_word(mode));
      end
      random_packet(ITEM_BUDGET - sent_beats);
      send_packet();
    end
    steady <= 1'b0;

    wait_drained();
    if (fail_count == 0) begin
      $display("keyed_response_bit_scrambler: match");
    end else begin
      $display("keyed_response_bit_scrambler: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/kbs_pkg.sv
sv/kbs_in_if.sv
sv/kbs_out_if.sv
sv/kbs_capture.sv
sv/kbs_emit.sv
sv/keyed_response_bit_scrambler.sv
tb/kbs_payload_checker.sv
tb/tb_keyed_response_bit_scrambler.sv
